[src/gostctr_pkg.sv]
// ----------------------------------------------------------------------------
// gostctr_pkg: shared types, constants and functions
// Round function tables, counter steps and controller/datapath command words.
// ----------------------------------------------------------------------------
`default_nettype none

package gostctr_pkg;

  localparam int unsigned WordW       = 32;
  localparam int unsigned NumKeys     = 8;
  localparam int unsigned KeyIdxW     = 3;
  localparam int unsigned CfgIdxW     = 4;
  localparam int unsigned RoundW      = 5;
  localparam int unsigned LastRound   = 31;
  localparam int unsigned FwdRounds   = 24;
  localparam int unsigned RotAmt      = 11;

  // blocks per chunk before the counter is reloaded
  localparam int unsigned ChunkBlocks = 512;
  localparam int unsigned ChunkW      = (ChunkBlocks > 1) ? $clog2(ChunkBlocks) : 1;

  localparam logic [WordW-1:0] IvWord0  = 32'h591dcb84;
  localparam logic [WordW-1:0] IvWord1  = 32'hcba84b2c;
  localparam logic [WordW-1:0] StepLow  = 32'h01010101;
  localparam logic [WordW-1:0] StepHigh = 32'h01010104;

  localparam logic [WordW-1:0] KeyReset [NumKeys] = '{
    32'hf7aa4c98, 32'hbf62c067, 32'h0b524334, 32'hbc28a2d0,
    32'h6b57c2d1, 32'h233843aa, 32'hc06d0210, 32'h38d4f804
  };

  localparam logic [3:0] SBox [8][16] = '{
    '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
      4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12},
    '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
      4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
    '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
      4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
    '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
      4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
    '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
      4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
    '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
      4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
    '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
      4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
    '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
      4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3}
  };

  // S-box substitution per byte lane, then rotate left
  function automatic logic [WordW-1:0] gost_f(input logic [WordW-1:0] x);
    logic [WordW-1:0] r;
    r = '0;
    for (int l = 0; l < 4; l++) begin
      r[8*l+4 +: 4] = SBox[6-2*l][x[8*l+4 +: 4]];
      r[8*l   +: 4] = SBox[7-2*l][x[8*l   +: 4]];
    end
    return {r[WordW-RotAmt-1:0], r[WordW-1:WordW-RotAmt]};
  endfunction

  // add with end-around carry
  function automatic logic [WordW-1:0] add_eac(input logic [WordW-1:0] x,
                                               input logic [WordW-1:0] c);
    logic [WordW:0] s;
    s = {1'b0, x} + {1'b0, c};
    return s[WordW-1:0] + {{(WordW-1){1'b0}}, s[WordW]};
  endfunction

  typedef struct packed {
    logic              accept;
    logic              load_iv;
    logic              step;
    logic              step_from_iv;
    logic              round_en;
    logic [RoundW-1:0] round_idx;
    logic              load_out;
  } gc_cmd_t;

  typedef struct packed {
    logic reload;
  } gc_status_t;

endpackage

`default_nettype wire

[src/gostctr_ctrl.sv]
// ----------------------------------------------------------------------------
// gostctr_ctrl: sequencing controller
// Steps the shared round unit through IV and keystream runs, owns tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module gostctr_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  input  wire  gostctr_pkg::gc_status_t status_i,
  output gostctr_pkg::gc_cmd_t   cmd_o
);
  import gostctr_pkg::*;

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StIvRnd  = 3'd1;
  localparam logic [2:0] StStepIv = 3'd2;
  localparam logic [2:0] StStep   = 3'd3;
  localparam logic [2:0] StKsRnd  = 3'd4;
  localparam logic [2:0] StDone   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [RoundW-1:0] round_q, round_d;
  logic              ovalid_q, ovalid_d;
  logic              last_round;

  assign last_round = (round_q == RoundW'(LastRound));

  always_comb begin
    state_d  = state_q;
    round_d  = round_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.round_idx = round_q;
    in_ready_o = (state_q == StIdle);
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          round_d = '0;
          if (status_i.reload) begin
            cmd_o.load_iv = 1'b1;
            state_d = StIvRnd;
          end else begin
            state_d = StStep;
          end
        end
      end
      StIvRnd: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 1'b1;
        if (last_round) state_d = StStepIv;
      end
      StStepIv: begin
        cmd_o.step = 1'b1;
        cmd_o.step_from_iv = 1'b1;
        state_d = StKsRnd;
      end
      StStep: begin
        cmd_o.step = 1'b1;
        state_d = StKsRnd;
      end
      StKsRnd: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 1'b1;
        if (last_round) state_d = StDone;
      end
      StDone: begin
        // hold the result until the output register is free
        if (!ovalid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          ovalid_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      round_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      round_q  <= round_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

endmodule

`default_nettype wire

[src/gostctr_dp.sv]
// ----------------------------------------------------------------------------
// gostctr_dp: cipher datapath
// Subkeys, counter, chunk position, one shared round unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gostctr_dp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire  [gostctr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [gostctr_pkg::WordW-1:0]      cfg_wdata_i,
  input  wire                                first_i,
  input  wire  [2*gostctr_pkg::WordW-1:0]    data_i,
  input  wire  gostctr_pkg::gc_cmd_t         cmd_i,
  output gostctr_pkg::gc_status_t            status_o,
  output logic [2*gostctr_pkg::WordW-1:0]    result_o
);
  import gostctr_pkg::*;

  logic [WordW-1:0]   key_q [NumKeys];
  logic [WordW-1:0]   ctr_lo_q, ctr_hi_q;
  logic [WordW-1:0]   a_q, b_q;
  logic [2*WordW-1:0] data_q, res_q;
  logic [ChunkW-1:0]  pos_q;

  logic [ChunkW-1:0]  pos_base;
  logic [ChunkW:0]    pos_inc;
  logic [ChunkW-1:0]  pos_d;
  logic [KeyIdxW-1:0] key_idx;
  logic [WordW-1:0]   rnd_src, rnd_f;
  logic [WordW-1:0]   src_lo, src_hi, nxt_lo, nxt_hi;

  // chunk restart on a first block or on wrap
  assign pos_base = first_i ? '0 : pos_q;
  assign pos_inc  = {1'b0, pos_base} + 1'b1;
  assign pos_d    = (pos_inc >= (ChunkW+1)'(ChunkBlocks)) ? '0 : pos_inc[ChunkW-1:0];
  assign status_o.reload = first_i || (pos_q == '0);

  // subkeys 0..7 three times forward, then 7..0
  assign key_idx = (cmd_i.round_idx < RoundW'(FwdRounds)) ? cmd_i.round_idx[KeyIdxW-1:0]
                                                          : ~cmd_i.round_idx[KeyIdxW-1:0];
  assign rnd_src = cmd_i.round_idx[0] ? b_q : a_q;
  assign rnd_f   = gost_f(key_q[key_idx] + rnd_src);

  // cipher output is swapped: (b, a)
  assign src_lo = cmd_i.step_from_iv ? b_q : ctr_lo_q;
  assign src_hi = cmd_i.step_from_iv ? a_q : ctr_hi_q;
  assign nxt_lo = add_eac(src_lo, StepLow);
  assign nxt_hi = add_eac(src_hi, StepHigh);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeys; i++) key_q[i] <= KeyReset[i];
      ctr_lo_q <= '0;
      ctr_hi_q <= '0;
      pos_q    <= '0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < CfgIdxW'(NumKeys))) begin
        key_q[cfg_idx_i[KeyIdxW-1:0]] <= cfg_wdata_i;
      end
      if (cmd_i.accept) pos_q <= pos_d;
      if (cmd_i.step) begin
        ctr_lo_q <= nxt_lo;
        ctr_hi_q <= nxt_hi;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) data_q <= data_i;
    if (cmd_i.load_iv) begin
      a_q <= IvWord0;
      b_q <= IvWord1;
    end else if (cmd_i.step) begin
      a_q <= nxt_lo;
      b_q <= nxt_hi;
    end else if (cmd_i.round_en) begin
      if (cmd_i.round_idx[0]) a_q <= a_q ^ rnd_f;
      else                    b_q <= b_q ^ rnd_f;
    end
    if (cmd_i.load_out) begin
      res_q <= data_q ^ {a_q, b_q};
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

[src/gost_counter_mode_keystream_xor.sv]
// ----------------------------------------------------------------------------
// gost_counter_mode_keystream_xor: GOST 28147-89 counter-mode XOR
// Controller and datapath for one 64-bit block per word.
// ----------------------------------------------------------------------------
// Each input word is XORed with a keystream pair made by enciphering a
// running counter with 32 GOST rounds (subkeys 0..7 three times, then 7..0).
// A word with tuser set, or the first word of every 512-block chunk (also the
// first word after reset), reloads the counter with the encryption of the
// fixed IV. One shared round unit does one round per cycle. A block goes
// through accept, counter step, 32 rounds and result load, and tvalid rises
// together with the registered result; on a reload the IV is loaded at
// accept and 32 IV rounds come before the counter step. The block takes
// one word at a time; a finished result waits in the output register while
// the next word is already taken. Subkeys are to be written through the cfg
// port only while idle, which the block itself does not enforce; an index of
// 8 or more is dropped. Encryption and decryption are the same operation.
`default_nettype none

module gost_counter_mode_keystream_xor (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // configuration write port
  input  wire                                cfg_we_i,
  input  wire  [gostctr_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire  [gostctr_pkg::WordW-1:0]      cfg_wdata_i,
  // input stream
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [2*gostctr_pkg::WordW-1:0]    s_axis_tdata,  // data_low, data_high
  input  wire                                s_axis_tuser,  // first_block
  // output stream
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  output logic [2*gostctr_pkg::WordW-1:0]    m_axis_tdata   // out_low, out_high
);
  import gostctr_pkg::*;

  gc_cmd_t    cmd;
  gc_status_t status;

  // sequence rounds and the output handshake
  gostctr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // hold subkeys, counter and chunk position; run the rounds
  gostctr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .first_i     (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (m_axis_tdata)
  );

endmodule

`default_nettype wire
